// File: rtl/core/sjfrq_pkg.sv
// ----------------------------------------------------------------------------
// sjfrq_pkg
// types and constants of the shortest-job-first ready queue
// ----------------------------------------------------------------------------
package sjfrq_pkg;

   localparam int SLOT_W = 6;
   localparam int TIME_W = 16;
   localparam int KEY_W  = 3 * TIME_W + SLOT_W;

   // request word: slot, burst, arrival, pid, remaining from the lowest bit
   localparam int REQ_DATA_W = 72;
   // response word: slot, slice length from the lowest bit
   localparam int RSP_DATA_W = 24;

   // request kind carried on tuser
   localparam logic CMD_ARRIVE   = 1'b0;
   localparam logic CMD_DISPATCH = 1'b1;

   // queue entry; the sort key occupies the upper bits so that one unsigned
   // compare of the key orders burst, then arrival, then pid, then slot
   typedef struct packed {
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] pid;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] remaining;
   } entry_type;

endpackage

// File: rtl/core/shortest_job_first_ready_queue_core.sv
// ----------------------------------------------------------------------------
// shortest_job_first_ready_queue_core
// ready queue of a non-preemptive shortest-job-first scheduler
// ----------------------------------------------------------------------------
// arrival: written on acceptance into an empty queue, dropped when full,
//   otherwise placed by the insertion shift (one memory read and write per
//   moved entry); a dispatch registers its response word from the head if any
// throughput: one word at a time; a dispatch holds the input until its reply
//   is registered, an arrival for the insertion shift, one entry per cycle
// reset: synchronous, clears the fill count, head pointer and state; the
//   entry memory is not cleared, only entries inside the live window are read
// ----------------------------------------------------------------------------
module shortest_job_first_ready_queue_core #(
   parameter int MAX_PROCS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // slot[5:0], expected_burst[21:6], arrival_time[37:22], proc_pid[53:38],
   // remaining_time[69:54], zero fill above
   input  logic [sjfrq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd[0]: 0 arrival, 1 dispatch
   input  logic                               req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // chosen_slot[5:0], slice_length[21:6], zero fill above
   output logic [sjfrq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // found[0]
   output logic                               rsp_tuser
);
   import sjfrq_pkg::*;

   localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam int SW = AW + 1;

   // the queue is kept sorted in a circular buffer: the head is always the
   // best entry, so a dispatch just pops it; an arrival is placed by shifting
   // larger entries one place towards the tail, walking back from the tail
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_POP,
      ST_NONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     pos_ff, pos_in;      // write target of the shift
   logic [CW-1:0]     left_ff, left_in;    // entries still to compare
   entry_type         new_ff, new_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [TIME_W-1:0] rsp_len_ff, rsp_len_in;

   // entry memory, one write and one registered read per cycle
   entry_type         entry_mem_ff [MAX_PROCS];
   entry_type         rd_data_ff;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   entry_type         wr_data;
   logic              mem_we;

   entry_type         req_entry;
   logic [AW-1:0]     tail;
   logic [SW-1:0]     tail_sum;
   logic              rsp_free;
   logic              moves_down;

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
      next_idx = (i == AW'(MAX_PROCS - 1)) ? '0 : i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] i);
      prev_idx = (i == '0) ? AW'(MAX_PROCS - 1) : i - AW'(1);
   endfunction

   // unpack the request word
   always_comb begin
      req_entry.slot      = req_tdata[SLOT_W-1:0];
      req_entry.burst     = req_tdata[SLOT_W +: TIME_W];
      req_entry.arrival   = req_tdata[SLOT_W + TIME_W +: TIME_W];
      req_entry.pid       = req_tdata[SLOT_W + 2*TIME_W +: TIME_W];
      req_entry.remaining = req_tdata[SLOT_W + 3*TIME_W +: TIME_W];
   end

   // first free place after the live window, wrapped round the buffer
   assign tail_sum = SW'(head_ff) + SW'(count_ff);
   assign tail     = (tail_sum >= SW'(MAX_PROCS)) ? AW'(tail_sum - SW'(MAX_PROCS))
                                                  : AW'(tail_sum);

   // strictly larger entries move; equal keys stay ahead of the newcomer,
   // which keeps the queue order for full ties
   assign moves_down = rd_data_ff[TIME_W +: KEY_W] > new_ff[TIME_W +: KEY_W];
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      new_in       = new_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_len_in   = rsp_len_ff;
      rd_addr      = head_ff;
      wr_addr      = pos_ff;
      wr_data      = new_ff;
      mem_we       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == CMD_DISPATCH) begin
                  state_in = (count_ff == '0) ? ST_NONE : ST_POP;
               end else if (count_ff == CW'(MAX_PROCS)) begin
                  // full queue, arrival dropped
                  state_in = ST_IDLE;
               end else if (count_ff == '0) begin
                  mem_we   = 1'b1;
                  wr_addr  = tail;
                  wr_data  = req_entry;
                  count_in = count_ff + CW'(1);
               end else begin
                  new_in   = req_entry;
                  pos_in   = tail;
                  left_in  = count_ff;
                  rd_addr  = prev_idx(tail);
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (moves_down) begin
               mem_we  = 1'b1;
               wr_data = rd_data_ff;
               pos_in  = prev_idx(pos_ff);
               left_in = left_ff - CW'(1);
               rd_addr = prev_idx(prev_idx(pos_ff));
               if (left_ff == CW'(1)) begin
                  state_in = ST_PLACE;
               end
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = ST_IDLE;
            end
         end
         ST_PLACE: begin
            mem_we   = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = ST_IDLE;
         end
         ST_POP: begin
            // read address held on the head while the output is busy
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_slot_in  = rd_data_ff.slot;
               rsp_len_in   = rd_data_ff.remaining;
               head_in      = next_idx(head_ff);
               count_in     = count_ff - CW'(1);
               state_in     = ST_IDLE;
            end
         end
         ST_NONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_slot_in  = '0;
               rsp_len_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         pos_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      new_ff       <= new_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_len_ff   <= rsp_len_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {(RSP_DATA_W - SLOT_W - TIME_W)'(0), rsp_len_ff, rsp_slot_ff};

   // fill count never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_PROCS))
      else $error("queue fill count above depth");

   // an empty dispatch reports zeros
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("not-found word carries data");

   // the shift never runs with nothing left to compare
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (left_ff != '0))
      else $error("shift with empty compare window");

   // an arrival into a full queue leaves the count alone
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_ARRIVE
       && count_ff == CW'(MAX_PROCS)) |=> $stable(count_ff))
      else $error("dropped arrival changed the fill count");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the shortest-job-first ready queue core
// ----------------------------------------------------------------------------
// arrival and dispatch words go in on the request stream. A software copy of
// the ready queue predicts each dispatch: smallest burst, then earliest
// arrival, then lowest pid, then lowest slot, then the entry queued first.
// Every response word is checked field by field against the oldest
// prediction. The run covers directed corner cases, a fill past capacity and
// long random traffic under four idling regimes on both streams.
// ----------------------------------------------------------------------------
module testbench;

   import sjfrq_pkg::*;

   localparam int QUEUE_DEPTH  = 64;
   // an arrival into a nearly full queue shifts every entry, so allow for that
   localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
   localparam int CYCLE_LIMIT  = 1000000;

   // one dispatch outcome as the response word carries it
   typedef struct {
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] slice;
   } dispatch_outcome_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // slot, burst, arrival, pid, remaining from the lowest bit, zero fill above
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // cmd: arrival or dispatch
   logic                  req_tuser  = CMD_ARRIVE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // chosen slot, slice length from the lowest bit, zero fill above
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // found
   logic                  rsp_tuser;

   // software copy of the ready queue, kept in insertion order
   entry_type            ready_list[$];
   dispatch_outcome_type expected_dispatches[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   shortest_job_first_ready_queue_core #(
      .MAX_PROCS (QUEUE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------
   // scheduling order of the predictor
   // ---------------------------------------------------------------------

   // strict order on the full key; equal keys keep insertion order
   function automatic bit runs_sooner(input entry_type a, input entry_type b);
      return {a.burst, a.arrival, a.pid, a.slot} < {b.burst, b.arrival, b.pid, b.slot};
   endfunction

   // removes the entry that would be dispatched and returns the outcome
   function automatic dispatch_outcome_type pick_shortest_job();
      dispatch_outcome_type outcome;
      int                   best;
      int                   i;
      outcome.found = 1'b0;
      outcome.slot  = '0;
      outcome.slice = '0;
      if (ready_list.size() == 0) return outcome;
      best = 0;
      for (i = 1; i < ready_list.size(); i++) begin
         if (runs_sooner(ready_list[i], ready_list[best])) best = i;
      end
      outcome.found = 1'b1;
      outcome.slot  = ready_list[best].slot;
      outcome.slice = ready_list[best].remaining;
      ready_list.delete(best);
      return outcome;
   endfunction

   function automatic entry_type make_entry(input int slot, input int burst,
                                            input int arrival, input int pid,
                                            input int remaining);
      entry_type e;
      e.slot      = slot[SLOT_W-1:0];
      e.burst     = burst[TIME_W-1:0];
      e.arrival   = arrival[TIME_W-1:0];
      e.pid       = pid[TIME_W-1:0];
      e.remaining = remaining[TIME_W-1:0];
      return e;
   endfunction

   // key fields either over the full range or squeezed to force ties
   function automatic int key_field(input bit narrow);
      return narrow ? $urandom_range(3) : $urandom_range(16'hFFFF);
   endfunction

   function automatic entry_type random_entry(input bit narrow);
      return make_entry(narrow ? $urandom_range(3) : $urandom_range(63),
                        key_field(narrow && $urandom_range(1)),
                        key_field(narrow && $urandom_range(1)),
                        key_field(narrow && $urandom_range(1)),
                        $urandom_range(16'hFFFF));
   endfunction

   // ---------------------------------------------------------------------
   // request driver: idles at random, then holds the word until accepted
   // ---------------------------------------------------------------------
   task automatic send_word(input logic cmd, input entry_type e);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, e.remaining, e.pid, e.arrival, e.burst, e.slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // accepted at this edge: update the software queue
      if (cmd == CMD_DISPATCH) begin
         expected_dispatches.push_back(pick_shortest_job());
      end else if (ready_list.size() < QUEUE_DEPTH) begin
         ready_list.push_back(e);
      end
   endtask

   task automatic arrive(input entry_type e);
      send_word(CMD_ARRIVE, e);
   endtask

   // data fields of a dispatch are don't-care, so fill them with noise
   task automatic dispatch();
      send_word(CMD_DISPATCH, random_entry(1'b0));
   endtask

   // ---------------------------------------------------------------------
   // response checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      dispatch_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_dispatches.size() == 0) begin
            $error("response word with no dispatch outstanding: found %0b slot %0d slice %0d",
                   rsp_tuser, rsp_tdata[5:0], rsp_tdata[21:6]);
            mismatch_count++;
         end else begin
            want = expected_dispatches.pop_front();
            if (rsp_tuser !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[5:0] !== want.slot) begin
               $error("chosen_slot: expected %0d, got %0d", want.slot, rsp_tdata[5:0]);
               mismatch_count++;
            end
            if (rsp_tdata[21:6] !== want.slice) begin
               $error("slice_length: expected %0d, got %0d", want.slice, rsp_tdata[21:6]);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // dispatch from an empty queue reports not found with zero fields
   task automatic test_empty_dispatch();
      dispatch();
      dispatch();
   endtask

   // all-zero, all-one and alternating fields, bursts one apart at the top
   task automatic test_field_extremes();
      arrive(make_entry(63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      arrive(make_entry(0, 0, 0, 0, 0));
      arrive(make_entry(42, 16'hFFFE, 16'h5555, 16'hAAAA, 16'h5555));
      arrive(make_entry(21, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA));
      repeat (4) dispatch();
      dispatch();
   endtask

   // each tie breaker in turn, a full key tie on the same slot and a
   // repeated slot; expected order out is F, D, E, C, B, A
   task automatic test_tie_breaks();
      arrive(make_entry(10, 5, 9, 1, 100));          // A
      arrive(make_entry(11, 5, 3, 7, 101));          // B: earlier arrival
      arrive(make_entry(12, 5, 3, 2, 102));          // C: lower pid
      arrive(make_entry(4, 5, 3, 2, 103));           // D: lower slot
      arrive(make_entry(4, 5, 3, 2, 104));           // E: same key, queued later
      arrive(make_entry(4, 4, 16'hFFFF, 16'hFFFF, 105)); // F: smaller burst
      repeat (6) dispatch();
   endtask

   // fill past capacity so the extra arrivals are dropped, then drain
   task automatic test_full_queue();
      send_idle_pct  = 13;
      recv_stall_pct = 13;
      repeat (QUEUE_DEPTH + 2) arrive(random_entry($urandom_range(1)));
      repeat (QUEUE_DEPTH + 2) dispatch();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   // mixed traffic; the arrival share is redrawn every few dozen words so
   // the queue swings between empty, part full and full
   task automatic test_random_traffic(input int word_count, input int send_pct,
                                      input int stall_pct);
      int arrive_pct;
      int n;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      arrive_pct     = 50;
      for (n = 0; n < word_count; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(3))
               0: arrive_pct = 25;
               1: arrive_pct = 50;
               2: arrive_pct = 65;
               default: arrive_pct = 90;
            endcase
         end
         if ($urandom_range(99) < arrive_pct) arrive(random_entry($urandom_range(2) == 0));
         else dispatch();
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_dispatch();
      test_field_extremes();
      test_tie_breaks();
      test_full_queue();
      test_random_traffic(300, 0, 0);
      test_random_traffic(300, 61, 0);
      test_random_traffic(300, 0, 61);
      test_random_traffic(300, 13, 13);

      req_tvalid <= 1'b0;
      while (expected_dispatches.size() != 0) @(posedge clock);
      // let any late insertion shift settle and catch stray response words
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_dispatches.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
